[design/japd_pkg.sv]
// Package for the joint angle PID drive: widths, register indexes,
// microcode control word and the program table of the sequencer.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package japd_pkg;

	localparam int INTEGRAL_BITS = 24;

	localparam int RAW_W  = 8;
	localparam int DEG_W  = 9;
	localparam int GAIN_W = 16;
	localparam int ERR_W  = 10;
	localparam int DERR_W = 11;
	localparam int DIFF_W = 10;
	localparam int ANG_W  = 12;
	localparam int DUTY_W = 8;

	localparam int CFG_AW = 3;
	localparam int CFG_DW = 16;
	localparam int IN_DW  = 24;
	localparam int OUT_DW = 16;

	// division by 255 as multiply by reciprocal: q = (m * RECIP) >> RECIP_SHIFT
	localparam int ABS_W       = 17;
	localparam int RECIP       = 131587;
	localparam int RECIP_SHIFT = 25;
	localparam int QUO_W       = 9;

	localparam int MUL_A_W = (INTEGRAL_BITS > ABS_W + 1) ? INTEGRAL_BITS : ABS_W + 1;
	localparam int MUL_B_W = 19;
	localparam int PROD_W  = MUL_A_W + MUL_B_W;
	localparam int ACC_W   = PROD_W + 2;
	localparam int FRAC_W  = 8;
	localparam int RES_W   = ACC_W - FRAC_W;

	localparam int PC_W = 4;

	localparam logic [CFG_AW-1:0] REG_GAIN_P   = CFG_AW'(0);
	localparam logic [CFG_AW-1:0] REG_GAIN_I   = CFG_AW'(1);
	localparam logic [CFG_AW-1:0] REG_GAIN_D   = CFG_AW'(2);
	localparam logic [CFG_AW-1:0] REG_RANGE_LO = CFG_AW'(3);
	localparam logic [CFG_AW-1:0] REG_RANGE_HI = CFG_AW'(4);

	localparam logic [PC_W-1:0] PC_IDLE  = PC_W'(0);
	localparam logic [PC_W-1:0] PC_MAP   = PC_W'(1);
	localparam logic [PC_W-1:0] PC_DIV   = PC_W'(2);
	localparam logic [PC_W-1:0] PC_ERR   = PC_W'(3);
	localparam logic [PC_W-1:0] PC_INTEG = PC_W'(4);
	localparam logic [PC_W-1:0] PC_PTERM = PC_W'(5);
	localparam logic [PC_W-1:0] PC_ITERM = PC_W'(6);
	localparam logic [PC_W-1:0] PC_DTERM = PC_W'(7);
	localparam logic [PC_W-1:0] PC_OUT   = PC_W'(8);

	typedef enum logic [2:0] {
		A_RAW, A_ABS, A_ERR, A_SUM, A_DERR
	} a_sel_t;

	typedef enum logic [2:0] {
		B_DIFF, B_RECIP, B_KP, B_KI, B_KD
	} b_sel_t;

	typedef enum logic [2:0] {
		OP_NONE, OP_SIGN, OP_ERR, OP_INTEG, OP_LOAD, OP_ADD, OP_OUT
	} op_t;

	typedef enum logic [1:0] {
		J_NEXT, J_WAIT_IN, J_WAIT_OUT
	} jmp_t;

	typedef struct packed {
		a_sel_t           a_sel;
		b_sel_t           b_sel;
		logic             mul_en;
		op_t              op;
		jmp_t             jmp;
		logic [PC_W-1:0]  target;
	} uword_t;

	function automatic uword_t ucode(input logic [PC_W-1:0] pc);
		uword_t w;
		w = '{a_sel: A_RAW, b_sel: B_DIFF, mul_en: 1'b0, op: OP_NONE,
			jmp: J_NEXT, target: PC_IDLE};
		unique case (pc)
			PC_IDLE: begin
				w.jmp = J_WAIT_IN;
			end
			PC_MAP: begin
				w.a_sel  = A_RAW;
				w.b_sel  = B_DIFF;
				w.mul_en = 1'b1;
			end
			PC_DIV: begin
				w.a_sel  = A_ABS;
				w.b_sel  = B_RECIP;
				w.mul_en = 1'b1;
				w.op     = OP_SIGN;
			end
			PC_ERR: begin
				w.op = OP_ERR;
			end
			PC_INTEG: begin
				w.a_sel  = A_ERR;
				w.b_sel  = B_KP;
				w.mul_en = 1'b1;
				w.op     = OP_INTEG;
			end
			PC_PTERM: begin
				w.a_sel  = A_SUM;
				w.b_sel  = B_KI;
				w.mul_en = 1'b1;
				w.op     = OP_LOAD;
			end
			PC_ITERM: begin
				w.a_sel  = A_DERR;
				w.b_sel  = B_KD;
				w.mul_en = 1'b1;
				w.op     = OP_ADD;
			end
			PC_DTERM: begin
				w.op = OP_ADD;
			end
			PC_OUT: begin
				w.op     = OP_OUT;
				w.jmp    = J_WAIT_OUT;
				w.target = PC_IDLE;
			end
			default: begin
				w.jmp    = J_WAIT_OUT;
				w.target = PC_IDLE;
			end
		endcase
		return w;
	endfunction

endpackage

`default_nettype wire

[design/joint_angle_pid_drive.sv]
// Joint angle PID drive: microcoded sequencer around one shared multiplier.
// A new input item is accepted only in the idle step, once the nine-step program on the
// single multiplier has run and its result has been written to the output register;
// the output step holds while an earlier result has not yet been taken.
// Reset clears the sequencer, integral and prior error, and loads default gains and range.
// Depends on japd_pkg.
`timescale 1ns / 1ps
`default_nettype none

module joint_angle_pid_drive
	import japd_pkg::*;
(
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              cfg_we,
	input  wire logic [CFG_AW-1:0] cfg_addr,
	input  wire logic [CFG_DW-1:0] cfg_wdata,
	input  wire logic              s_tvalid,
	output logic                   s_tready,
	input  wire logic [IN_DW-1:0]  s_tdata,   // sensor_raw[7:0], target_deg[16:8], zero fill
	output logic                   m_tvalid,
	input  wire logic              m_tready,
	output logic [OUT_DW-1:0]      m_tdata    // reverse[0], duty[8:1], zero fill
);

	logic signed [GAIN_W-1:0]        gain_p_q, gain_i_q, gain_d_q;
	logic signed [DEG_W-1:0]         range_lo_q, range_hi_q;

	logic [PC_W-1:0]                 pc_q, pc_d;
	uword_t                          uw;

	logic [RAW_W-1:0]                raw_q;
	logic signed [DEG_W-1:0]         target_q;
	logic signed [PROD_W-1:0]        prod_q, prod_neg;
	logic signed [ACC_W-1:0]         acc_q;
	logic                            neg_q;
	logic signed [ERR_W-1:0]         err_q, prior_q, err_d;
	logic signed [DERR_W-1:0]        derr_q;
	logic signed [INTEGRAL_BITS-1:0] sum_q, sum_d;
	logic signed [INTEGRAL_BITS:0]   sum_ext;

	logic signed [MUL_A_W-1:0]       a_mux;
	logic signed [MUL_B_W-1:0]       b_mux;
	logic signed [DIFF_W-1:0]        diff;
	logic [ABS_W-1:0]                abs_v;
	logic [QUO_W-1:0]                quo;
	logic signed [ANG_W-1:0]         quo_s, dev;
	logic signed [RES_W-1:0]         res, mag;
	logic                            res_pos;
	logic [DUTY_W-1:0]               duty_d;

	logic                            out_busy, out_wr, in_acc;
	logic                            rev_q;
	logic [DUTY_W-1:0]               duty_q;
	logic                            out_valid_q;

	assign uw       = ucode(pc_q);
	assign s_tready = (uw.jmp == J_WAIT_IN);
	assign in_acc   = s_tvalid && s_tready;
	assign out_busy = out_valid_q && !m_tready;
	assign out_wr   = (uw.op == OP_OUT) && !out_busy;

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {{(OUT_DW - DUTY_W - 1){1'b0}}, duty_q, rev_q};

	always_comb begin
		unique case (uw.jmp)
			J_NEXT:     pc_d = pc_q + PC_W'(1);
			J_WAIT_IN:  pc_d = s_tvalid ? pc_q + PC_W'(1) : pc_q;
			J_WAIT_OUT: pc_d = out_busy ? pc_q : uw.target;
			default:    pc_d = PC_IDLE;
		endcase
	end

	// shared multiplier operands
	assign diff     = DIFF_W'(range_hi_q) - DIFF_W'(range_lo_q);
	assign prod_neg = -prod_q;
	assign abs_v    = prod_q[PROD_W-1] ? prod_neg[ABS_W-1:0] : prod_q[ABS_W-1:0];

	always_comb begin
		unique case (uw.a_sel)
			A_RAW:   a_mux = $signed(MUL_A_W'(raw_q));
			A_ABS:   a_mux = $signed(MUL_A_W'(abs_v));
			A_ERR:   a_mux = MUL_A_W'(err_q);
			A_SUM:   a_mux = MUL_A_W'(sum_q);
			A_DERR:  a_mux = MUL_A_W'(derr_q);
			default: a_mux = '0;
		endcase
		unique case (uw.b_sel)
			B_DIFF:  b_mux = MUL_B_W'(diff);
			B_RECIP: b_mux = MUL_B_W'(RECIP);
			B_KP:    b_mux = MUL_B_W'(gain_p_q);
			B_KI:    b_mux = MUL_B_W'(gain_i_q);
			B_KD:    b_mux = MUL_B_W'(gain_d_q);
			default: b_mux = '0;
		endcase
	end

	// angle and clamped error
	assign quo   = prod_q[RECIP_SHIFT +: QUO_W];
	assign quo_s = $signed(ANG_W'(quo));
	assign dev   = ANG_W'(range_lo_q) + (neg_q ? -quo_s : quo_s) - ANG_W'(target_q);

	always_comb begin
		priority if (dev < -ANG_W'(512))
			err_d = {1'b1, {(ERR_W - 1){1'b0}}};
		else if (dev > ANG_W'(511))
			err_d = {1'b0, {(ERR_W - 1){1'b1}}};
		else
			err_d = dev[ERR_W-1:0];
	end

	// saturating integral
	assign sum_ext = (INTEGRAL_BITS + 1)'(sum_q) + (INTEGRAL_BITS + 1)'(err_q);

	always_comb begin
		if (sum_ext[INTEGRAL_BITS] != sum_ext[INTEGRAL_BITS-1])
			sum_d = sum_ext[INTEGRAL_BITS] ? {1'b1, {(INTEGRAL_BITS - 1){1'b0}}}
				: {1'b0, {(INTEGRAL_BITS - 1){1'b1}}};
		else
			sum_d = sum_ext[INTEGRAL_BITS-1:0];
	end

	// floor shift, direction and magnitude saturation
	assign res     = acc_q[ACC_W-1:FRAC_W];
	assign res_pos = !res[RES_W-1] && (|res);
	assign mag     = res_pos ? res : -res;
	assign duty_d  = (|mag[RES_W-1:DUTY_W]) ? {DUTY_W{1'b1}} : mag[DUTY_W-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gain_p_q   <= GAIN_W'(2560);
			gain_i_q   <= GAIN_W'(2560);
			gain_d_q   <= GAIN_W'(2560);
			range_lo_q <= DEG_W'(0);
			range_hi_q <= DEG_W'(90);
		end else if (cfg_we) begin
			unique case (cfg_addr)
				REG_GAIN_P:   gain_p_q   <= cfg_wdata;
				REG_GAIN_I:   gain_i_q   <= cfg_wdata;
				REG_GAIN_D:   gain_d_q   <= cfg_wdata;
				REG_RANGE_LO: range_lo_q <= cfg_wdata[DEG_W-1:0];
				REG_RANGE_HI: range_hi_q <= cfg_wdata[DEG_W-1:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pc_q        <= PC_IDLE;
			sum_q       <= '0;
			prior_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			pc_q <= pc_d;
			if (uw.op == OP_INTEG) begin
				sum_q   <= sum_d;
				prior_q <= err_q;
			end
			if (out_wr)
				out_valid_q <= 1'b1;
			else if (m_tready)
				out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			raw_q    <= s_tdata[RAW_W-1:0];
			target_q <= s_tdata[RAW_W +: DEG_W];
		end
		if (uw.mul_en)
			prod_q <= PROD_W'(a_mux * b_mux);
		unique case (uw.op)
			OP_SIGN:  neg_q  <= prod_q[PROD_W-1];
			OP_ERR:   err_q  <= err_d;
			OP_INTEG: derr_q <= DERR_W'(err_q) - DERR_W'(prior_q);
			OP_LOAD:  acc_q  <= ACC_W'(prod_q);
			OP_ADD:   acc_q  <= acc_q + ACC_W'(prod_q);
			OP_OUT: begin
				if (out_wr) begin
					rev_q  <= !res_pos;
					duty_q <= duty_d;
				end
			end
			default: ;
		endcase
	end

	a_accept_starts: assert property (@(posedge clk) disable iff (!arst_n)
		in_acc |=> pc_q == PC_MAP)
		else $error("accepted item did not start the program");

	a_out_from_step: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_tvalid) |-> $past(uw.op == OP_OUT))
		else $error("result raised outside the output step");

	a_hold_when_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(uw.op == OP_OUT) && out_busy |=> pc_q == $past(pc_q))
		else $error("sequencer advanced while the result slot was full");

	a_prior_tracks: assert property (@(posedge clk) disable iff (!arst_n)
		uw.op == OP_INTEG |=> prior_q == $past(err_q))
		else $error("prior error not updated from current error");

endmodule

`default_nettype wire
